FILE: hdl/char_stream_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef CHAR_STREAM_TOKENIZER_ASSERT_SVH
`define CHAR_STREAM_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTK_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ctk_pkg.sv
`timescale 1ns / 1ps

package ctk_pkg;

  // Longest token length that is counted; longer tokens saturate here.
  localparam logic [6:0] MAX_TOKEN_CHARS = 7'd99;

  // Depth of the result queue and its pointer and fill widths.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
  localparam int unsigned RES_CW    = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } scan_mode_e;

  typedef enum logic [3:0] {
    TOK_END    = 4'd0,
    TOK_LPAREN = 4'd1,
    TOK_RPAREN = 4'd2,
    TOK_LBRACE = 4'd3,
    TOK_RBRACE = 4'd4,
    TOK_EQUALS = 4'd5,
    TOK_SEMI   = 4'd6,
    TOK_VOID   = 4'd7,
    TOK_INT    = 4'd8,
    TOK_IDENT  = 4'd9,
    TOK_NUMBER = 4'd10
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic [6:0]  len;
    logic        last;
  } result_t;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword spellings.
  localparam logic [7:0] KW_VOID [4] = '{8'h76, 8'h6F, 8'h69, 8'h64};
  localparam logic [7:0] KW_INT  [3] = '{8'h69, 8'h6E, 8'h74};
  localparam logic [6:0] KW_VOID_LEN = 7'd4;
  localparam logic [6:0] KW_INT_LEN  = 7'd3;

endpackage

FILE: hdl/char_stream_tokenizer.sv
// Character stream tokenizer.
// Input channel: one ASCII character per item on char_code_i, or an end of
// stream marker on end_of_input_i, moved by in_valid_i / in_ready_o.
// Output channel: one token per item (token_kind_o, token_length_o and
// last_of_run_o) moved by out_valid_o / out_ready_i. An input item gives
// zero, one or two tokens; last_of_run_o marks the final one of its group.
// Each accepted character is classified and the scanner state updated in
// the same cycle; its tokens are written into a four-entry result queue,
// and out_valid_o is high in the cycle after acceptance.
// Throughput is one input item per cycle while in_ready_o is high. The
// queue takes an item whenever it holds at most two tokens, so items that
// produce two tokens can fill it while the receiver drains one per cycle.
// When the receiver stalls, the queue fills and in_ready_o falls once three
// or more tokens wait; nothing is dropped.
// Reset (rst_ni low, asynchronous) returns the scanner to idle with no
// token in progress and empties the result queue.
`timescale 1ns / 1ps

module char_stream_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_kind_o,
  output logic [6:0] token_length_o,
  output logic       last_of_run_o
);
  import ctk_pkg::*;

  // Scanner state.
  scan_mode_e mode_q, mode_d;
  logic [6:0] count_q, count_d;
  logic       void_q, void_d;
  logic       int_q, int_d;

  // Result queue.
  result_t           res_mem_q [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CW-1:0] fill_q;

  logic in_acc, out_acc;
  assign in_ready_o  = (fill_q <= RES_CW'(RES_DEPTH - 2));
  assign out_valid_o = (fill_q != '0);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  // Character classes.
  logic is_letter, is_digit, is_skip, is_cspace, in_token, cont;
  token_kind_e punct_kind;
  logic        is_punct;

  always_comb begin
    is_letter = char_code_i inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
    is_digit  = char_code_i inside {[CH_DIG_LO:CH_DIG_HI]};
    is_skip   = char_code_i inside {CH_SPACE, CH_NL, CH_TAB};
    is_cspace = char_code_i inside {CH_SPACE, CH_NL, CH_TAB, CH_VT, CH_FF, CH_CR};
    is_punct  = 1'b1;
    case (char_code_i)
      CH_LPAREN: punct_kind = TOK_LPAREN;
      CH_RPAREN: punct_kind = TOK_RPAREN;
      CH_LBRACE: punct_kind = TOK_LBRACE;
      CH_RBRACE: punct_kind = TOK_RBRACE;
      CH_EQUALS: punct_kind = TOK_EQUALS;
      CH_SEMI:   punct_kind = TOK_SEMI;
      default: begin
        punct_kind = TOK_END;
        is_punct   = 1'b0;
      end
    endcase
    // Mode value 3 cannot occur and is treated as idle.
    in_token = (mode_q == MODE_WORD) || (mode_q == MODE_NUM);
    if (mode_q == MODE_WORD) begin
      cont = !end_of_input_i && (is_letter || is_digit || char_code_i == CH_UNDER);
    end else begin
      cont = !end_of_input_i && is_digit;
    end
  end

  // What the character does when seen from idle: the token it emits, if
  // any.
  logic        idle_emit;
  token_kind_e idle_kind;
  logic [6:0]  idle_len;

  always_comb begin
    idle_emit = 1'b0;
    idle_kind = TOK_END;
    idle_len  = 7'd0;
    if (is_skip) begin
      idle_emit = 1'b0;
    end else if (is_punct) begin
      idle_emit = 1'b1;
      idle_kind = punct_kind;
      idle_len  = 7'd1;
    end else if (!is_letter && !is_digit) begin
      // Unknown characters emit an end token.
      idle_emit = 1'b1;
    end
  end

  // Next state of the scanner.
  logic [1:0] kw_pos;
  always_comb begin
    kw_pos  = (count_q < KW_INT_LEN) ? count_q[1:0] : 2'd0;
    mode_d  = MODE_IDLE;
    count_d = 7'd0;
    void_d  = 1'b0;
    int_d   = 1'b0;
    if (in_token && cont) begin
      mode_d  = mode_q;
      count_d = (count_q < MAX_TOKEN_CHARS) ? count_q + 7'd1 : count_q;
      if (mode_q == MODE_WORD) begin
        void_d = void_q && (count_q < KW_VOID_LEN) && (char_code_i == KW_VOID[count_q[1:0]]);
        int_d  = int_q && (count_q < KW_INT_LEN) && (char_code_i == KW_INT[kw_pos]);
      end
    end else if (!end_of_input_i && !(in_token && is_cspace)) begin
      // The character is handled again from idle.
      if (is_letter) begin
        mode_d  = MODE_WORD;
        count_d = 7'd1;
        void_d  = (char_code_i == KW_VOID[0]);
        int_d   = (char_code_i == KW_INT[0]);
      end else if (is_digit) begin
        mode_d  = MODE_NUM;
        count_d = 7'd1;
      end
    end
  end

  // Tokens caused by the character.
  token_kind_e tok_kind;
  result_t     res0, res1;
  logic [1:0]  push_n;

  always_comb begin
    if (mode_q == MODE_NUM) begin
      tok_kind = TOK_NUMBER;
    end else if (void_q && count_q == KW_VOID_LEN) begin
      tok_kind = TOK_VOID;
    end else if (int_q && count_q == KW_INT_LEN) begin
      tok_kind = TOK_INT;
    end else begin
      tok_kind = TOK_IDENT;
    end
    res0   = '{kind: TOK_END, len: 7'd0, last: 1'b1};
    res1   = '{kind: TOK_END, len: 7'd0, last: 1'b1};
    push_n = 2'd0;
    if (in_token) begin
      if (!cont) begin
        res0 = '{kind: tok_kind, len: count_q, last: 1'b0};
        if (end_of_input_i) begin
          push_n = 2'd2;
        end else if (is_cspace) begin
          push_n = 2'd1;
        end else if (idle_emit) begin
          res1   = '{kind: idle_kind, len: idle_len, last: 1'b1};
          push_n = 2'd2;
        end else begin
          push_n = 2'd1;
        end
        res0.last = (push_n == 2'd1);
      end
    end else if (end_of_input_i) begin
      push_n = 2'd1;
    end else if (idle_emit) begin
      res0   = '{kind: idle_kind, len: idle_len, last: 1'b1};
      push_n = 2'd1;
    end
  end

  logic [1:0] push_acc;
  assign push_acc = in_acc ? push_n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      count_q  <= 7'd0;
      void_q   <= 1'b0;
      int_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (in_acc) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        void_q  <= void_d;
        int_q   <= int_d;
      end
      wr_ptr_q <= wr_ptr_q + RES_AW'(push_acc);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + RES_AW'(1);
      end
      fill_q <= fill_q + RES_CW'(push_acc) - RES_CW'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc != 2'd0) begin
      res_mem_q[wr_ptr_q] <= res0;
    end
    if (push_acc == 2'd2) begin
      res_mem_q[wr_ptr_q + RES_AW'(1)] <= res1;
    end
  end

  result_t res_out;
  assign res_out        = res_mem_q[rd_ptr_q];
  assign token_kind_o   = res_out.kind;
  assign token_length_o = res_out.len;
  assign last_of_run_o  = res_out.last;

  `include "char_stream_tokenizer_assert.svh"

  `CTK_ASSERT_SAME(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= RES_CW'(RES_DEPTH), "result queue overflow")
  `CTK_ASSERT_SAME(a_token_nonempty, clk_i, rst_ni, mode_q != MODE_IDLE, count_q != 7'd0 && (mode_q == MODE_WORD || mode_q == MODE_NUM), "token mode with empty count")
  `CTK_ASSERT_SAME(a_kw_in_word, clk_i, rst_ni, void_q || int_q, mode_q == MODE_WORD && count_q <= KW_VOID_LEN, "keyword match outside a short word")
  `CTK_ASSERT_NEXT(a_result_shows, clk_i, rst_ni, in_acc && push_n != 2'd0, out_valid_o, "token pushed but output not valid")

endmodule
